FILE: hw/rtl/vwma_pkg.sv
// shared constants, types and helpers of the weighted moving average block
package vwma_pkg;

  // sizing
  localparam int MAX_ELEMENTS = 1024;
  localparam int MAX_WINDOW   = 8;
  localparam int HIST_SLOTS   = MAX_WINDOW - 1;
  localparam int DEPTH        = HIST_SLOTS * MAX_ELEMENTS;

  // field widths
  localparam int SAMPLE_W   = 24;
  localparam int WL_W       = 4;
  localparam int VL_W       = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // register reset values
  localparam int WL_RESET = 5;
  localparam int VL_RESET = 1024;

  // derived widths
  localparam int POS_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int SLOT_W = (HIST_SLOTS > 1) ? $clog2(HIST_SLOTS) : 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int W_W    = $clog2(MAX_WINDOW + 1);
  localparam int FS_W   = $clog2(HIST_SLOTS + 1);
  localparam int TMAX   = MAX_WINDOW * (MAX_WINDOW - 1) / 2;
  localparam int T_W    = $clog2(TMAX + 1);
  localparam int MAG_W  = SAMPLE_W - 1 + T_W;
  localparam int ACC_W  = MAG_W + 1;
  localparam int RCP_W  = MAG_W + 1;
  localparam int PROD_W = MAG_W + RCP_W;
  localparam int CMP_W  = (VL_W > POS_W + 1) ? VL_W : POS_W + 1;
  localparam int WC_W   = (WL_W > W_W) ? WL_W : W_W;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_FIX,
    ST_OUT
  } vwma_state_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_VECTOR_LENGTH = 2'd1
  } vwma_reg_t;

  // sum of the linear weights 0..w-1, one for a window of one
  function automatic int weight_sum(input int w);
    int s;
    s = (w <= 1) ? 1 : (w * (w - 1)) / 2;
    return s;
  endfunction

endpackage

FILE: hw/rtl/vwma_in_if.sv
// sample input channel: one vector element per word
interface vwma_in_if;
  import vwma_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       frame_end;

  modport source (output valid, output sample, output frame_end, input ready);
  modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

FILE: hw/rtl/vwma_out_if.sv
// result channel: one weighted average per word
interface vwma_out_if;
  import vwma_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] average;
  logic                       last_of_frame;

  modport source (output valid, output average, output last_of_frame, input ready);
  modport sink   (input valid, input average, input last_of_frame, output ready);
endinterface

FILE: hw/rtl/vwma_cfg_if.sv
// configuration write channel: register index and write data
interface vwma_cfg_if;
  import vwma_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/vector_weighted_moving_average.sv
// sequence: an accepted word runs the history read loop, W-2 reads for an effective window W
//   of three or more and none for one or two, one read of the history memory per cycle,
//   then the reciprocal divide (multiply, correct, load); the block takes no new word until
//   the load, and the next word is taken while a result waits in the output register
// reset: clears position, frame count, newest slot and sequencer, registers return to
//   window 5 and vector 1024; the history memory is not cleared
module vector_weighted_moving_average (
  input logic       clk,
  input logic       rst_n,
  vwma_in_if.sink   in_s,
  vwma_out_if.source out_m,
  vwma_cfg_if.sink  cfg_s
);
  import vwma_pkg::*;

  // configuration registers
  logic [WL_W-1:0] wl_cfg_r;
  logic [VL_W-1:0] vl_cfg_r;

  // block state
  vwma_state_t      state_r, state_nxt;
  logic [POS_W-1:0]  elem_pos_r;
  logic [FS_W-1:0]   frames_r;
  logic [SLOT_W-1:0] newest_r;

  // per-word working registers
  logic signed [SAMPLE_W-1:0] x_r;
  logic [POS_W-1:0]           pos_r;
  logic                       closing_r;
  logic [W_W-1:0]             w_r;
  logic [W_W-1:0]             wt_r;
  logic [W_W-1:0]             pwt_r;
  logic                       pend_r;
  logic [SLOT_W-1:0]          rd_slot_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       neg_r;
  logic [MAG_W-1:0]           mag_r;
  logic [PROD_W-1:0]          prod_r;
  logic [MAG_W-1:0]           q0_r;
  logic [MAG_W-1:0]           rem_r;

  // output register
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] avg_r;
  logic                       last_r;

  // history memory
  logic signed [SAMPLE_W-1:0] hist_mem [DEPTH];
  logic signed [SAMPLE_W-1:0] mem_q_r;

  logic              accept;
  logic              in_ready;
  logic              rd_en;
  logic              wr_en;
  logic              out_load;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [SLOT_W-1:0] wr_slot;
  logic [SLOT_W-1:0] prev_slot;

  // weight sums and their reciprocals, one entry per window size
  logic [RCP_W-1:0] recip_tab [MAX_WINDOW+1];
  logic [T_W-1:0]   wsum_tab  [MAX_WINDOW+1];

  for (genvar g = 0; g <= MAX_WINDOW; g++) begin : g_recip
    localparam int     TS  = weight_sum(g);
    localparam longint RCP = (longint'(1) << MAG_W) / TS;
    assign recip_tab[g] = RCP_W'(RCP);
    assign wsum_tab[g]  = T_W'(TS);
  end

  function automatic logic [ADDR_W-1:0] hist_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [POS_W-1:0] p);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(ADDR_W'(s) * ADDR_W'(MAX_ELEMENTS)) + ADDR_W'(p);
    return a;
  endfunction

  // effective window and vector length
  logic [WC_W-1:0]  wl_ext;
  logic [W_W-1:0]   wl_eff;
  logic [CMP_W-1:0] vl_ext;
  logic [CMP_W-1:0] vl_eff;
  logic [CMP_W-1:0] pos_ext;
  logic [POS_W-1:0] pos_in;
  logic             closing_in;
  logic [W_W-1:0]   fs_p1;
  logic [W_W-1:0]   w_in;
  logic [W_W-1:0]   w_m1;
  logic signed [ACC_W-1:0] acc_init;

  always_comb begin
    wl_ext = WC_W'(wl_cfg_r);
    if (wl_ext == '0) begin
      wl_eff = W_W'(1);
    end else if (wl_ext > WC_W'(MAX_WINDOW)) begin
      wl_eff = W_W'(MAX_WINDOW);
    end else begin
      wl_eff = W_W'(wl_ext);
    end

    vl_ext = CMP_W'(vl_cfg_r);
    if (vl_ext == '0) begin
      vl_eff = CMP_W'(1);
    end else if (vl_ext > CMP_W'(MAX_ELEMENTS)) begin
      vl_eff = CMP_W'(MAX_ELEMENTS);
    end else begin
      vl_eff = vl_ext;
    end

    pos_ext    = CMP_W'(elem_pos_r);
    closing_in = in_s.frame_end || (pos_ext >= vl_eff - CMP_W'(1));
    pos_in     = (pos_ext >= vl_eff) ? POS_W'(vl_eff - CMP_W'(1)) : elem_pos_r;

    fs_p1 = W_W'(frames_r) + W_W'(1);
    w_in  = (fs_p1 > wl_eff) ? wl_eff : fs_p1;
    w_m1  = w_in - W_W'(1);

    // the current word carries weight w-1; a window of one passes it through
    if (w_in == W_W'(1)) begin
      acc_init = ACC_W'(in_s.sample);
    end else begin
      acc_init = ACC_W'(in_s.sample) * ACC_W'($signed({1'b0, w_m1}));
    end
  end

  // slot arithmetic around the ring of history slots
  always_comb begin
    wr_slot   = (newest_r == SLOT_W'(HIST_SLOTS - 1)) ? '0 : newest_r + SLOT_W'(1);
    prev_slot = (rd_slot_r == '0) ? SLOT_W'(HIST_SLOTS - 1) : rd_slot_r - SLOT_W'(1);
    rd_addr   = hist_addr(rd_slot_r, pos_r);
    wr_addr   = hist_addr(wr_slot, pos_r);
  end

  // sequencer next state and strobes
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_s.valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        rd_en = (wt_r != '0);
        if (!rd_en && !pend_r) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        wr_en     = 1'b1;
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_m.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign accept = in_s.valid && in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_cfg_r <= WL_W'(WL_RESET);
      vl_cfg_r <= VL_W'(VL_RESET);
    end else if (cfg_s.valid) begin
      case (cfg_s.index)
        REG_WINDOW_LENGTH: wl_cfg_r <= cfg_s.data[WL_W-1:0];
        REG_VECTOR_LENGTH: vl_cfg_r <= cfg_s.data[VL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_s.ready = 1'b1;
  assign in_s.ready  = in_ready;

  // frame position, frame count and newest slot, advanced at write back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_pos_r <= '0;
      frames_r   <= '0;
      newest_r   <= '0;
    end else if (wr_en) begin
      if (closing_r) begin
        newest_r   <= wr_slot;
        elem_pos_r <= '0;
        if (frames_r < FS_W'(HIST_SLOTS)) begin
          frames_r <= frames_r + FS_W'(1);
        end
      end else begin
        elem_pos_r <= pos_r + POS_W'(1);
      end
    end
  end

  // read loop control; each issued read carries the weight it lands with
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      wt_r   <= '0;
    end else if (accept) begin
      pend_r <= 1'b0;
      wt_r   <= (w_in > W_W'(2)) ? w_in - W_W'(2) : '0;
    end else if (state_r == ST_READ) begin
      pend_r <= rd_en;
      if (rd_en) begin
        wt_r <= wt_r - W_W'(1);
      end
    end
  end

  // word capture and weighted accumulation
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r       <= in_s.sample;
      pos_r     <= pos_in;
      closing_r <= closing_in;
      w_r       <= w_in;
      rd_slot_r <= newest_r;
      acc_r     <= acc_init;
    end else if (state_r == ST_READ) begin
      if (rd_en) begin
        rd_slot_r <= prev_slot;
      end
      pwt_r <= wt_r;
      if (pend_r) begin
        acc_r <= acc_r + ACC_W'(mem_q_r) * ACC_W'($signed({1'b0, pwt_r}));
      end
    end
  end

  // history memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= x_r;
    end
    if (rd_en) begin
      mem_q_r <= hist_mem[rd_addr];
    end
  end

  // divide by the weight sum: reciprocal multiply, then one remainder correction
  logic signed [ACC_W-1:0] acc_neg;
  logic [MAG_W-1:0]        mag;
  logic [MAG_W-1:0]        wsum_ext;
  logic [MAG_W-1:0]        q0;
  logic [MAG_W-1:0]        q_fix;
  logic [MAG_W-1:0]        q_signed;

  always_comb begin
    acc_neg  = -acc_r;
    mag      = acc_r[ACC_W-1] ? acc_neg[MAG_W-1:0] : acc_r[MAG_W-1:0];
    wsum_ext = MAG_W'(wsum_tab[w_r]);
    q0       = prod_r[MAG_W+MAG_W-1:MAG_W];
    q_fix    = q0_r + MAG_W'(rem_r >= wsum_ext);
    q_signed = neg_r ? -q_fix : q_fix;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      neg_r  <= acc_r[ACC_W-1];
      mag_r  <= mag;
      prod_r <= PROD_W'(mag) * PROD_W'(recip_tab[w_r]);
    end
    if (state_r == ST_FIX) begin
      q0_r  <= q0;
      rem_r <= mag_r - MAG_W'(q0 * wsum_ext);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_m.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      avg_r  <= q_signed[SAMPLE_W-1:0];
      last_r <= closing_r;
    end
  end

  assign out_m.valid         = out_valid_r;
  assign out_m.average       = avg_r;
  assign out_m.last_of_frame = last_r;

  // checks on the sequencer and the divide
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("history read and write in the same cycle");

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_s.ready)
    else $error("input taken again before the word finished");

  a_frames_bound: assert property (@(posedge clk) disable iff (!rst_n)
    frames_r <= FS_W'(HIST_SLOTS))
    else $error("frame count beyond the history depth");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (rem_r < (wsum_ext << 1)))
    else $error("reciprocal quotient off by more than one");

endmodule
